// ----- sv/nfsf_pkg.sv -----
`default_nettype none
package nfsf_pkg;

	localparam int SLOT_COUNT = 16;

	localparam int ID_W   = 8;
	localparam int POS_W  = 16;
	localparam int SQ_W   = 32;
	localparam int DIST_W = 34;

	localparam logic [1:0] CMD_FIND    = 2'd0;
	localparam logic [1:0] CMD_RESERVE = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;
	localparam logic [1:0] CMD_PLACE   = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_RESERVED  = 3'd1;
	localparam logic [2:0] ST_AVAILABLE = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_NONE      = 3'd4;

	// Query token that walks the cell chain, carrying the running best.
	typedef struct packed {
		logic                    valid;
		logic signed [POS_W-1:0] qx;
		logic signed [POS_W-1:0] qy;
		logic                    have;
		logic [DIST_W-1:0]       best;
		logic [ID_W-1:0]         best_id;
		logic [ID_W-1:0]         id;
	} token_t;

	// Table update strobes for one cell.
	typedef struct packed {
		logic                    load;
		logic                    set_free;
		logic                    clr_free;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
	} cell_wr_t;

endpackage
`default_nettype wire

// ----- sv/nearest_free_slot_finder.sv -----
// Timing: reserve, release and place answer in the cycle after acceptance; a find answers
// once its query token has passed all cells (two register stages per slot cell).
// Throughput: one request at a time; a find holds the input for the full walk of the
// query token down the cell chain, others can follow every cycle while out_ready is high.
// Reset (arst_n low, asynchronous): all slots at (0,0) and available, no request in flight,
// no result pending.
`default_nettype none
module nearest_free_slot_finder import nfsf_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              command,
	input  wire logic [ID_W-1:0]         spot_id,
	input  wire logic signed [POS_W-1:0] pos_x,
	input  wire logic signed [POS_W-1:0] pos_y,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [2:0]                   status,
	output logic [ID_W-1:0]              found_id
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic [2:0] status_q;
	logic [ID_W-1:0] found_q;

	token_t tok [SLOT_COUNT+1];
	cell_wr_t wr [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] free_vec;
	logic [SLOT_COUNT-1:0] sel;

	logic accept;
	logic id_ok;
	logic sel_free;
	logic [2:0] status_d;
	token_t last;

	// Take a new request only when no find is walking the chain and the
	// result register is empty or being drained this cycle.
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign id_ok    = (spot_id != '0) && (spot_id <= ID_W'(SLOT_COUNT));

	// Decode the addressed slot per cell; avoids an indexed read of the table.
	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			sel[i] = id_ok && (spot_id == ID_W'(i + 1));
		end
		sel_free = |(sel & free_vec);
	end

	// Status of the table commands (reserve, release, place).
	always_comb begin
		status_d = ST_OK;
		if (!id_ok) begin
			status_d = ST_NOT_FOUND;
		end else begin
			case (command)
				CMD_RESERVE: status_d = sel_free ? ST_OK : ST_RESERVED;
				CMD_RELEASE: status_d = sel_free ? ST_AVAILABLE : ST_OK;
				default:     status_d = ST_OK;
			endcase
		end
	end

	// Launch the query token into the head cell on an accepted find.
	always_comb begin
		tok[0].valid   = accept && (command == CMD_FIND);
		tok[0].qx      = pos_x;
		tok[0].qy      = pos_y;
		tok[0].have    = 1'b0;
		tok[0].best    = '0;
		tok[0].best_id = '0;
		tok[0].id      = ID_W'(1);
	end

	// Drive per-cell update strobes; only an addressed, accepted request writes.
	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			wr[i].load     = accept && sel[i] && (command == CMD_PLACE);
			wr[i].set_free = accept && sel[i] && (command == CMD_RELEASE);
			wr[i].clr_free = accept && sel[i] && (command == CMD_RESERVE);
			wr[i].x        = pos_x;
			wr[i].y        = pos_y;
		end
	end

	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
		nfsf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr[g]),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1]),
			.free    (free_vec[g])
		);
	end

	assign last = tok[SLOT_COUNT];

	// Sequence: idle, or wait for the token to leave the tail cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (command == CMD_FIND)) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (last.valid) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register: load on a table command or on the finished find,
	// drop when the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && (command != CMD_FIND)) ||
		             ((state_q == ST_SCAN) && last.valid)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (command != CMD_FIND)) begin
			status_q <= status_d;
			found_q  <= '0;
		end else if ((state_q == ST_SCAN) && last.valid) begin
			status_q <= last.have ? ST_OK : ST_NONE;
			found_q  <= last.have ? last.best_id : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found_id  = found_q;

endmodule
`default_nettype wire

// ----- sv/nfsf_cell.sv -----
`default_nettype none
module nfsf_cell import nfsf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cell_wr_t wr,
	input  wire token_t   tok_in,
	output token_t        tok_out,
	output logic          free
);

	logic signed [POS_W-1:0] x_q;
	logic signed [POS_W-1:0] y_q;
	logic                    free_q;

	token_t          tok_s1;
	logic            free_s1;
	logic [SQ_W-1:0] sqx_s1;
	logic [SQ_W-1:0] sqy_s1;
	token_t          tok_s2;

	logic signed [POS_W:0] dx;
	logic signed [POS_W:0] dy;
	logic [POS_W-1:0]      ax;
	logic [POS_W-1:0]      ay;
	logic [DIST_W-1:0]     dist_sum;
	logic                  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			free_q <= 1'b1;
		end else if (wr.load) begin
			x_q    <= wr.x;
			y_q    <= wr.y;
			free_q <= 1'b1;
		end else if (wr.set_free) begin
			free_q <= 1'b1;
		end else if (wr.clr_free) begin
			free_q <= 1'b0;
		end
	end

	assign free = free_q;

	// Stage 1: squared differences of the query against this slot.
	always_comb begin
		dx = 17'(tok_in.qx) - 17'(x_q);
		dy = 17'(tok_in.qy) - 17'(y_q);
		ax = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
		ay = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1  <= '0;
			free_s1 <= 1'b0;
			sqx_s1  <= '0;
			sqy_s1  <= '0;
		end else begin
			tok_s1  <= tok_in;
			free_s1 <= free_q;
			sqx_s1  <= SQ_W'(ax) * SQ_W'(ax);
			sqy_s1  <= SQ_W'(ay) * SQ_W'(ay);
		end
	end

	// Stage 2: sum, strict compare so the lowest index wins a tie.
	always_comb begin
		dist_sum = DIST_W'(sqx_s1) + DIST_W'(sqy_s1);
		take     = free_s1 && (!tok_s1.have || dist_sum < tok_s1.best);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2 <= '0;
		end else begin
			tok_s2.valid   <= tok_s1.valid;
			tok_s2.qx      <= tok_s1.qx;
			tok_s2.qy      <= tok_s1.qy;
			tok_s2.have    <= tok_s1.have | take;
			tok_s2.best    <= take ? dist_sum : tok_s1.best;
			tok_s2.best_id <= take ? tok_s1.id : tok_s1.best_id;
			tok_s2.id      <= ID_W'(tok_s1.id + ID_W'(1));
		end
	end

	assign tok_out = tok_s2;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
module tb_top;
	import nfsf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no handshake on either side before the run is abandoned.
	// A find walk, sender gaps and receiver stalls are far shorter, so this leaves a wide margin.
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_REQUESTS = 1900;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              command;
	logic [ID_W-1:0]         spot_id;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic                    out_valid;
	logic                    out_ready;
	logic [2:0]              status;
	logic [ID_W-1:0]         found_id;

	// One answer that the block owes for an accepted request.
	typedef struct packed {
		logic [2:0]      status;
		logic [ID_W-1:0] found;
	} slot_answer_t;

	// Mirror of the slot table plus the queue of answers still owed.
	class slot_scoreboard;
		logic signed [POS_W-1:0] bay_x [SLOT_COUNT];
		logic signed [POS_W-1:0] bay_y [SLOT_COUNT];
		bit                      bay_open [SLOT_COUNT];
		slot_answer_t            owed [$];
		int                      errors;
		int                      checked;
		int                      empty_finds;
		int                      per_cmd [4];

		function void clear_table();
			int i;
			for (i = 0; i < SLOT_COUNT; i++) begin
				bay_x[i] = '0;
				bay_y[i] = '0;
				bay_open[i] = 1'b1;
			end
			owed.delete();
			errors = 0;
			checked = 0;
			empty_finds = 0;
			for (i = 0; i < 4; i++) per_cmd[i] = 0;
		endfunction

		// Update the mirror for one accepted request and queue its answer.
		function void note_request(logic [1:0] cmd, logic [ID_W-1:0] id,
				logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py);
			slot_answer_t ans;
			bit           have;
			longint       best;
			longint       dx;
			longint       dy;
			longint       span;
			int           i;
			int           k;
			ans.status = ST_OK;
			ans.found = '0;
			have = 1'b0;
			best = 0;
			per_cmd[cmd]++;
			if (cmd == CMD_FIND) begin
				// Scan in index order; strict less-than keeps the lowest id on a tie.
				for (i = 0; i < SLOT_COUNT; i++) begin
					if (bay_open[i]) begin
						dx = longint'(px) - longint'(bay_x[i]);
						dy = longint'(py) - longint'(bay_y[i]);
						span = dx * dx + dy * dy;
						if (!have || span < best) begin
							have = 1'b1;
							best = span;
							ans.found = ID_W'(i + 1);
						end
					end
				end
				if (!have) begin
					ans.status = ST_NONE;
					ans.found = '0;
					empty_finds++;
				end
			end else if (id == 0 || id > SLOT_COUNT) begin
				ans.status = ST_NOT_FOUND;
			end else begin
				k = int'(id) - 1;
				case (cmd)
				CMD_RESERVE: begin
					if (bay_open[k]) bay_open[k] = 1'b0;
					else ans.status = ST_RESERVED;
				end
				CMD_RELEASE: begin
					if (!bay_open[k]) bay_open[k] = 1'b1;
					else ans.status = ST_AVAILABLE;
				end
				default: begin
					bay_x[k] = px;
					bay_y[k] = py;
					bay_open[k] = 1'b1;
				end
				endcase
			end
			owed.push_back(ans);
		endfunction

		// Compare one delivered answer with the oldest one owed.
		function void check_result(logic [2:0] st, logic [ID_W-1:0] fid);
			slot_answer_t ans;
			checked++;
			if (owed.size() == 0) begin
				$display("%0t: result with nothing pending, status %0d found_id %0d",
					$time, st, fid);
				errors++;
				return;
			end
			ans = owed.pop_front();
			if (st !== ans.status) begin
				$display("%0t: status mismatch, expected %0d got %0d",
					$time, ans.status, st);
				errors++;
			end
			if (fid !== ans.found) begin
				$display("%0t: found_id mismatch, expected %0d got %0d",
					$time, ans.found, fid);
				errors++;
			end
		endfunction

		function int outstanding();
			return owed.size();
		endfunction
	endclass

	slot_scoreboard sb;
	int             sent;
	int             burst_left;
	int             quiet_cycles;

	nearest_free_slot_finder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.spot_id   (spot_id),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.found_id  (found_id)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Coordinate mix: mostly full range, some near the edges of the signed range,
	// some in a small window around the origin where ties are likely.
	function automatic logic signed [POS_W-1:0] rand_coord();
		int pick;
		int v;
		pick = $urandom_range(0, 19);
		if (pick < 3) begin
			case ($urandom_range(0, 6))
			0: return 16'sh8000;
			1: return 16'sh8001;
			2: return 16'shFFFF;
			3: return 16'sh0000;
			4: return 16'sh0001;
			5: return 16'sh7FFE;
			default: return 16'sh7FFF;
			endcase
		end
		if (pick < 6) begin
			v = $urandom_range(0, 128);
			return POS_W'(v - 64);
		end
		return POS_W'($urandom);
	endfunction

	// Mostly real slot ids, with zero and out-of-range ids mixed in.
	function automatic logic [ID_W-1:0] rand_id();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) return '0;
		if (pick == 1) return ID_W'($urandom_range(SLOT_COUNT + 1, 255));
		if (pick == 2) return ID_W'($urandom);
		return ID_W'($urandom_range(1, SLOT_COUNT));
	endfunction

	// Present one request from a falling edge and hold it until accepted.
	// Return on a falling edge; close the burst with an idle gap when it runs out.
	task automatic send_request(input logic [1:0] cmd, input logic [ID_W-1:0] id,
			input logic signed [POS_W-1:0] px, input logic signed [POS_W-1:0] py);
		command  <= cmd;
		spot_id  <= id;
		pos_x    <= px;
		pos_y    <= py;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_request(cmd, id, px, py);
		sent++;
		@(negedge clk);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			// Drop valid for an idle gap so it never falls and rises in one step.
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 8);
		end
	endtask

	// Receiver: replay an 8-bit ready mask that changes every so often.
	// The mask always keeps at least one bit set, so no stall lasts forever.
	initial begin
		logic [7:0] ready_mask;
		int         mask_pos;
		int         mask_left;
		out_ready = 1'b0;
		ready_mask = 8'hFF;
		mask_pos = 0;
		mask_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (mask_left == 0) begin
				if ($urandom_range(0, 3) == 0) ready_mask = 8'hFF;
				else ready_mask = 8'($urandom) | (8'h01 << $urandom_range(0, 7));
				mask_left = $urandom_range(16, 128);
			end
			out_ready <= ready_mask[mask_pos];
			mask_pos = (mask_pos + 1) % 8;
			mask_left--;
		end
	end

	// Check every answer the block delivers.
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(status, found_id);
	end

	// Watchdog: abandon the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d answers still pending",
					$time, QUIET_LIMIT, sb.outstanding());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int order [SLOT_COUNT];
		int i;
		int j;
		int t;
		int base_x;
		int base_y;
		int offs_x;
		int offs_y;
		int pick;
		sb = new;
		sb.clear_table();
		sent = 0;
		burst_left = $urandom_range(1, 8);
		quiet_cycles = 0;
		in_valid = 1'b0;
		command = CMD_FIND;
		spot_id = '0;
		pos_x = '0;
		pos_y = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. Every slot starts at the origin: the tie goes to id 1.
		send_request(CMD_FIND, 8'd0, 16'sh0000, 16'sh0000);
		// Park the first and last slots on opposite corners and query both corners.
		send_request(CMD_PLACE, 8'd1, 16'sh8000, 16'sh8000);
		send_request(CMD_PLACE, ID_W'(SLOT_COUNT), 16'sh7FFF, 16'sh7FFF);
		send_request(CMD_FIND, 8'hFF, 16'sh7FFF, 16'sh7FFF);
		send_request(CMD_FIND, 8'd0, 16'sh8000, 16'sh8000);
		// Id zero and ids past the table are not found.
		send_request(CMD_PLACE, 8'd0, 16'sh1234, 16'sh4321);
		send_request(CMD_RESERVE, ID_W'(SLOT_COUNT + 1), 16'sh0000, 16'sh0000);
		send_request(CMD_RELEASE, 8'hFF, 16'sh0000, 16'sh0000);
		// Double reserve and release of a free slot.
		send_request(CMD_RESERVE, 8'd1, 16'sh0000, 16'sh0000);
		send_request(CMD_RESERVE, 8'd1, 16'sh0000, 16'sh0000);
		send_request(CMD_RELEASE, 8'd2, 16'sh0000, 16'sh0000);
		// Take every remaining slot, then find must report none available.
		for (i = 2; i <= SLOT_COUNT; i++)
			send_request(CMD_RESERVE, ID_W'(i), 16'sh0000, 16'sh0000);
		send_request(CMD_FIND, 8'd0, 16'sh0000, 16'sh0000);
		send_request(CMD_RELEASE, 8'd1, 16'sh0000, 16'sh0000);
		send_request(CMD_FIND, 8'd0, 16'sh7FFF, 16'sh7FFF);

		// Random part, built from a few kinds of request sequences.
		while (sent < RANDOM_REQUESTS) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				// Free mix of all four commands.
				repeat ($urandom_range(10, 40)) begin
					j = $urandom_range(0, 19);
					if (j < 7) send_request(CMD_FIND, ID_W'($urandom), rand_coord(), rand_coord());
					else if (j < 12) send_request(CMD_RESERVE, rand_id(), rand_coord(), rand_coord());
					else if (j < 17) send_request(CMD_RELEASE, rand_id(), rand_coord(), rand_coord());
					else send_request(CMD_PLACE, rand_id(), rand_coord(), rand_coord());
				end
			end else if (pick < 8) begin
				// Fill the table in shuffled order, maybe free one slot, then search.
				for (i = 0; i < SLOT_COUNT; i++) order[i] = i + 1;
				for (i = SLOT_COUNT - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					t = order[i];
					order[i] = order[j];
					order[j] = t;
				end
				for (i = 0; i < SLOT_COUNT; i++)
					send_request(CMD_RESERVE, ID_W'(order[i]), rand_coord(), rand_coord());
				if ($urandom_range(0, 1) == 1)
					send_request(CMD_RELEASE, ID_W'($urandom_range(1, SLOT_COUNT)),
						rand_coord(), rand_coord());
				repeat ($urandom_range(1, 3))
					send_request(CMD_FIND, ID_W'($urandom), rand_coord(), rand_coord());
				repeat ($urandom_range(1, SLOT_COUNT))
					send_request(CMD_RELEASE, ID_W'($urandom_range(1, SLOT_COUNT)),
						rand_coord(), rand_coord());
				send_request(CMD_FIND, ID_W'($urandom), rand_coord(), rand_coord());
			end else begin
				// Pack slots tightly around one point so distances tie, then search nearby.
				base_x = int'($urandom_range(0, 65000)) - 32500;
				base_y = int'($urandom_range(0, 65000)) - 32500;
				repeat ($urandom_range(2, 8)) begin
					offs_x = int'($urandom_range(0, 8)) - 4;
					offs_y = int'($urandom_range(0, 8)) - 4;
					send_request(CMD_PLACE, ID_W'($urandom_range(1, SLOT_COUNT)),
						POS_W'(base_x + offs_x), POS_W'(base_y + offs_y));
				end
				repeat ($urandom_range(2, 6)) begin
					offs_x = int'($urandom_range(0, 12)) - 6;
					offs_y = int'($urandom_range(0, 12)) - 6;
					send_request(CMD_FIND, ID_W'($urandom),
						POS_W'(base_x + offs_x), POS_W'(base_y + offs_y));
				end
			end
		end

		// Stop sending, drain what is owed, then give a late extra answer time to show.
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (2 * SLOT_COUNT + 8) @(posedge clk);

		$display("Sent %0d requests: %0d finds (%0d with every slot taken), %0d reserves,",
			sent, sb.per_cmd[CMD_FIND], sb.empty_finds, sb.per_cmd[CMD_RESERVE]);
		$display("%0d releases, %0d places; %0d answers checked, %0d mismatches",
			sb.per_cmd[CMD_RELEASE], sb.per_cmd[CMD_PLACE], sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
sv/nfsf_pkg.sv
sv/nfsf_cell.sv
sv/nearest_free_slot_finder.sv
bench/tb_top.sv
